// File: rtl/temperature_sensor_readout_macros.svh
// Assertion macros used by the checker file of the temperature sensor readout.
`ifndef TEMPERATURE_SENSOR_READOUT_MACROS_SVH
`define TEMPERATURE_SENSOR_READOUT_MACROS_SVH

// signal holds while the word waits on its receiver
`define TSR_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    (vld && !rdy) |=> $stable(sig)) else $error(msg);

// same-cycle implication
`define TSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) \
    (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tsr_pkg.sv
// Types and constants of the temperature sensor readout.
`default_nettype none

package tsr_pkg;

  localparam int CODE_W = 12;
  localparam int TEMP_W = 14;

  // raw = floor((5094999 - 2000*code) * 1000 / 319137), zero for hot codes
  localparam logic [CODE_W-1:0] HOT_CODE    = 12'd2548;
  localparam logic [22:0]       CONV_OFFSET = 23'd5094999;
  localparam logic [22:0]       CONV_STEP   = 23'd2000;
  localparam logic [23:0]       RECIP_K     = 24'd13458067;  // floor(1000 * 2^32 / 319137)
  localparam logic [18:0]       CONV_DIV    = 19'd319137;
  localparam logic [9:0]        CONV_SCALE  = 10'd1000;

  // filter weights and reciprocals
  localparam logic [4:0]  OLD_WEIGHT = 5'd19;
  localparam logic [4:0]  SUM_WEIGHT = 5'd20;
  localparam logic [17:0] DIV5_M     = 18'd209716;   // ceil(2^20 / 5)
  localparam logic [14:0] DIV10_M    = 15'd26215;    // ceil(2^18 / 10)
  localparam logic [3:0]  TEN        = 4'd10;

  // characters
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // character slots of one line
  localparam logic [3:0] SLOT_LEAD   = 4'd0;
  localparam logic [3:0] SLOT_HUNDK  = 4'd1;
  localparam logic [3:0] SLOT_TENK   = 4'd2;
  localparam logic [3:0] SLOT_THOU   = 4'd3;
  localparam logic [3:0] SLOT_HUND   = 4'd4;
  localparam logic [3:0] SLOT_POINT  = 4'd5;
  localparam logic [3:0] SLOT_TENS   = 4'd6;
  localparam logic [3:0] SLOT_UNITS  = 4'd7;
  localparam logic [3:0] SLOT_CR     = 4'd8;
  localparam logic [3:0] SLOT_LF     = 4'd9;

  typedef struct packed {
    logic              valid;
    logic [TEMP_W-1:0] raw;
  } raw_word_t;

endpackage

`default_nettype wire

// File: rtl/temperature_sensor_readout.sv
// Temperature sensor readout: ADC code in, smoothed reading out as ASCII text.
//
// Input channel: one 12-bit ADC code per word (in_valid / in_ready).
// Output channel: one ASCII character per word (out_valid / out_ready), ten
// words per sample: "00ddd.dd" then CR LF. temp_hundredths carries the
// filtered reading on all ten words; last_char marks the line feed.
// Front: 3-stage conversion pipeline (reciprocal multiply plus one
// correction step) feeding a small queue of converted readings.
// Back: smoothing filter (19/20 old, 1/20 new; first sample primes it),
// 4-step decimal conversion, then the character emitter.
// The emitter sends one character per cycle while the receiver is ready;
// conversion of the next line overlaps the current one.
// Reset clears the pipelines, the queue and the filter; the next sample
// primes the filter again. When the receiver stalls, the emitter holds its
// character, the back part waits, the queue fills, and in_ready drops once
// the queue is full and the last front stage holds a reading.
`default_nettype none

module temperature_sensor_readout import tsr_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CODE_W-1:0] adc_sample,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             text_char,
  output logic [TEMP_W-1:0]      temp_hundredths,
  output logic                   last_char
);

  raw_word_t front_word;
  raw_word_t queue_word;
  logic      queue_ready;
  logic      queue_pop;

  tsr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .adc_sample (adc_sample),
    .conv       (front_word),
    .conv_ready (queue_ready)
  );

  tsr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (front_word),
    .wr_ready (queue_ready),
    .rd       (queue_word),
    .rd_pop   (queue_pop)
  );

  tsr_back u_back (
    .clk             (clk),
    .rst             (rst),
    .conv            (queue_word),
    .conv_pop        (queue_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .text_char       (text_char),
    .temp_hundredths (temp_hundredths),
    .last_char       (last_char)
  );

endmodule

`default_nettype wire

// File: rtl/tsr_queue.sv
// Small queue of converted readings between the front and back parts.
`default_nettype none

module tsr_queue import tsr_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire raw_word_t wr,
  output logic           wr_ready,
  output raw_word_t      rd,
  input  wire logic      rd_pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [TEMP_W-1:0] mem [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;
  logic              push;

  assign wr_ready = (count != CW'(DEPTH));
  assign push     = wr.valid && wr_ready;
  assign rd.valid = (count != '0);
  assign rd.raw   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr.raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, rd_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/tsr_front.sv
// Front part: takes ADC codes and converts them to hundredths of a degree.
`default_nettype none

module tsr_front import tsr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CODE_W-1:0] adc_sample,
  output raw_word_t              conv,
  input  wire logic              conv_ready
);

  logic              v1, v2, v3;
  logic [22:0]       m1, m2;
  logic [45:0]       p2;
  logic [TEMP_W-1:0] q3;
  logic [32:0]       prod3;
  logic [32:0]       num3;
  logic              adv;
  logic              hot;
  logic [22:0]       sub;
  logic [22:0]       m1_next;
  logic [32:0]       rem;

  assign adv      = !v3 || conv_ready;
  assign in_ready = adv;

  // hot codes clamp to zero by zeroing the numerator
  assign hot     = (adc_sample >= HOT_CODE);
  assign sub     = 23'(adc_sample) * CONV_STEP;
  assign m1_next = hot ? '0 : CONV_OFFSET - sub;

  // reciprocal estimate is low by at most one
  assign rem       = num3 - prod3;
  assign conv.valid = v3;
  assign conv.raw   = q3 + TEMP_W'(rem >= 33'(CONV_DIV));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1    <= m1_next;
      m2    <= m1;
      p2    <= 46'(m1) * 46'(RECIP_K);
      q3    <= p2[45:32];
      prod3 <= 33'(p2[45:32]) * 33'(CONV_DIV);
      num3  <= 33'(m2) * 33'(CONV_SCALE);
    end
  end

endmodule

`default_nettype wire

// File: rtl/tsr_back.sv
// Back part: smoothing filter, decimal conversion and character output.
`default_nettype none

module tsr_back import tsr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire raw_word_t         conv,
  output logic                   conv_pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [7:0]             text_char,
  output logic [TEMP_W-1:0]      temp_hundredths,
  output logic                   last_char
);

  // filter
  logic              va, vb, primed;
  logic [18:0]       sa;
  logic [33:0]       pb;
  logic [TEMP_W-1:0] prev;
  logic [TEMP_W-1:0] filt;
  logic              take;

  // decimal conversion
  logic              cv_busy, cv_done;
  logic [1:0]        cv_cnt;
  logic [TEMP_W-1:0] cv_val, cv_t;
  logic [15:0]       cv_digs;
  logic [TEMP_W-1:0] dq;
  logic [3:0]        drem;

  // character emitter
  logic              e_busy;
  logic [3:0]        e_idx;
  logic [TEMP_W-1:0] e_t;
  logic [15:0]       e_digs;
  logic [3:0]        e_top;
  logic              ld;
  logic              line_end;

  assign conv_pop = conv.valid && !va && !vb;
  assign filt     = pb[33:20];
  assign take     = vb && !cv_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      va     <= 1'b0;
      vb     <= 1'b0;
      primed <= 1'b0;
      prev   <= '0;
    end else begin
      va <= conv_pop;
      if (va) begin
        vb <= 1'b1;
      end else if (take) begin
        vb <= 1'b0;
      end
      if (take) begin
        prev   <= filt;
        primed <= 1'b1;
      end
    end
  end

  // first sample goes through as 20*raw/20
  always_ff @(posedge clk) begin
    if (conv_pop) begin
      sa <= primed ? 19'(prev) * 19'(OLD_WEIGHT) + 19'(conv.raw)
                   : 19'(conv.raw) * 19'(SUM_WEIGHT);
    end
    if (va) begin
      pb <= 34'(sa[18:2]) * 34'(DIV5_M);
    end
  end

  assign dq   = TEMP_W'((29'(cv_val) * 29'(DIV10_M)) >> 18);
  assign drem = 4'(cv_val - dq * TEMP_W'(TEN));

  assign line_end = e_busy && out_ready && (e_idx == SLOT_LF);
  assign ld       = cv_done && (!e_busy || line_end);

  always_ff @(posedge clk) begin
    if (rst) begin
      cv_busy <= 1'b0;
      cv_done <= 1'b0;
      cv_cnt  <= '0;
    end else if (take) begin
      cv_busy <= 1'b1;
      cv_done <= 1'b0;
      cv_cnt  <= '0;
    end else if (ld) begin
      cv_busy <= 1'b0;
      cv_done <= 1'b0;
    end else if (cv_busy && !cv_done) begin
      cv_done <= (cv_cnt == '1);
      cv_cnt  <= cv_cnt + 1'b1;
    end
  end

  // units digit shifts in first and ends in the low nibble
  always_ff @(posedge clk) begin
    if (take) begin
      cv_val <= filt;
      cv_t   <= filt;
    end else if (cv_busy && !cv_done) begin
      cv_val  <= dq;
      cv_digs <= {drem, cv_digs[15:4]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_busy <= 1'b0;
      e_idx  <= SLOT_LEAD;
    end else if (ld) begin
      e_busy <= 1'b1;
      e_idx  <= SLOT_LEAD;
    end else if (line_end) begin
      e_busy <= 1'b0;
    end else if (e_busy && out_ready) begin
      e_idx <= e_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      e_t    <= cv_t;
      e_digs <= cv_digs;
      e_top  <= cv_val[3:0];
    end
  end

  assign out_valid       = e_busy;
  assign temp_hundredths = e_t;
  assign last_char       = (e_idx == SLOT_LF);

  always_comb begin
    case (e_idx)
      SLOT_LEAD:  text_char = CH_ZERO;
      SLOT_HUNDK: text_char = CH_ZERO;
      SLOT_TENK:  text_char = CH_ZERO + 8'(e_top);
      SLOT_THOU:  text_char = CH_ZERO + 8'(e_digs[15:12]);
      SLOT_HUND:  text_char = CH_ZERO + 8'(e_digs[11:8]);
      SLOT_POINT: text_char = CH_POINT;
      SLOT_TENS:  text_char = CH_ZERO + 8'(e_digs[7:4]);
      SLOT_UNITS: text_char = CH_ZERO + 8'(e_digs[3:0]);
      SLOT_CR:    text_char = CH_CR;
      SLOT_LF:    text_char = CH_LF;
      default:    text_char = CH_ZERO;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/tsr_checker.sv
// Port-level checks of the temperature sensor readout, bound to the top level.
`default_nettype none
`include "temperature_sensor_readout_macros.svh"

module tsr_checker import tsr_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [7:0]        text_char,
  input wire logic [TEMP_W-1:0] temp_hundredths,
  input wire logic              last_char
);

  `TSR_ASSERT_HOLD(a_out_valid_hold, out_valid, out_ready, out_valid, "out_valid dropped")
  `TSR_ASSERT_IMP(a_last_is_lf, out_valid && last_char, text_char == CH_LF, "last not LF")
  `TSR_ASSERT_NEXT(a_line_no_gap, out_valid && out_ready && !last_char, out_valid, "line gap")
  `TSR_ASSERT_NEXT(a_temp_in_line, out_valid && out_ready && !last_char, $stable(temp_hundredths), "temp changed in line")

endmodule

bind temperature_sensor_readout tsr_checker u_tsr_checker (.*);

`default_nettype wire
